[sv/stepper_trapezoid_ramp_controller_defines.svh]
// Assertion macros for the stepper ramp controller checker.
// Stands alone; the checker file pulls it in by include.
`ifndef STEPPER_TRAPEZOID_RAMP_CONTROLLER_DEFINES_SVH
`define STEPPER_TRAPEZOID_RAMP_CONTROLLER_DEFINES_SVH

// Same-cycle implication, sampled on aclk and quiet during reset.
`define STRC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk and quiet during reset.
`define STRC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/strc_pkg.sv]
// Shared types, constants and helper functions of the stepper ramp controller.
// No dependencies; every other file but the defines header imports this package.
`default_nettype none

package strc_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int TABLE_AW    = $clog2(TABLE_DEPTH);

    localparam logic [7:0] JOG_RAMP_LIMIT    = 8'd20;
    localparam logic [7:0] SCALE_RESET       = 8'd254;
    localparam logic [7:0] SPEED_LIMIT_RESET = 8'd60;
    localparam logic [7:0] RAMP_LIMIT_RESET  = 8'd255;
    localparam logic [7:0] RAMP_CAP          = 8'd255;
    localparam logic [15:0] SHORT_MOVE_LEN   = 16'd1024;
    localparam logic [2:0] COILS_OFF         = 3'd7;

    localparam logic [0:0] CFG_INTERVAL_SCALE = 1'b0;
    localparam logic [0:0] CFG_SPEED_LIMIT    = 1'b1;

    typedef enum logic [2:0] {
        CMD_MOVE         = 3'd0,
        CMD_TICK         = 3'd1,
        CMD_TABLE_WRITE  = 3'd2,
        CMD_SET_POSITION = 3'd3,
        CMD_JOG          = 3'd4,
        CMD_STOP         = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        DIR_STOP   = 2'd0,
        DIR_LOWER  = 2'd1,
        DIR_HIGHER = 2'd2
    } dir_t;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_MOVE = 2'd1,
        MODE_JOG  = 2'd2
    } mode_t;

    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [15:0] target_position;
        logic               jog_toward_lower;
        logic [7:0]         table_address;
        logic [15:0]        table_word;
    } item_t;

    typedef struct packed {
        logic [2:0]         coil_pattern;
        logic signed [15:0] position_now;
        logic [15:0]        next_interval;
        logic               step_taken;
        logic               move_done;
        logic               busy_res;
    } result_t;

    typedef struct packed {
        logic                en;
        logic [TABLE_AW-1:0] addr;
        logic [15:0]         data;
    } tbl_wr_t;

    typedef struct packed {
        logic       en;
        logic [0:0] index;
        logic [7:0] data;
    } cfg_wr_t;

    function automatic logic [2:0] phase_coils(input logic [1:0] phase);
        logic [2:0] coils;
        unique case (phase)
            2'd0: coils = 3'd0;
            2'd1: coils = 3'd1;
            2'd2: coils = 3'd3;
            2'd3: coils = 3'd2;
            default: coils = COILS_OFF;
        endcase
        return coils;
    endfunction

    // Ramp indexes past the end of the table read the last entry.
    function automatic logic [TABLE_AW-1:0] table_slot(input logic [7:0] idx);
        logic [TABLE_AW-1:0] slot;
        if ({1'b0, idx} >= 9'(TABLE_DEPTH)) begin
            slot = TABLE_AW'(TABLE_DEPTH - 1);
        end else begin
            slot = idx[TABLE_AW-1:0];
        end
        return slot;
    endfunction

endpackage

`default_nettype wire

[sv/strc_table.sv]
// Acceleration table memory with one write port and one registered read port.
// Depends on strc_pkg for the depth and the write request type.
`default_nettype none

module strc_table
    import strc_pkg::*;
(
    input  wire logic                aclk,
    input  wire tbl_wr_t             wr,
    input  wire logic [TABLE_AW-1:0] rd_addr,
    output logic [15:0]              rd_data
);

    logic [15:0] mem [TABLE_DEPTH];
    logic [15:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    // A write to the address being read is passed straight to the read register.
    always_ff @(posedge aclk) begin
        if (wr.en && (wr.addr == rd_addr)) begin
            rd_data_reg <= wr.data;
        end else begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[sv/strc_ramp_core.sv]
// Motion state, ramp sequencing and result formation for one request per cycle on fire.
// Depends on strc_pkg; reads the acceleration table through strc_table.
`default_nettype none

module strc_ramp_core
    import strc_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire cfg_wr_t             cfg,
    input  wire logic                fire,
    input  wire item_t               item,
    input  wire logic [15:0]         rd_data,
    output tbl_wr_t                  tbl_wr,
    output logic [TABLE_AW-1:0]      rd_addr,
    output result_t                  res
);

    logic [7:0]  scale_reg,       scale_next;
    logic [7:0]  speed_limit_reg, speed_limit_next;
    logic [15:0] position_reg,    position_next;
    logic [1:0]  phase_reg,       phase_next;
    dir_t        dir_reg,         dir_next;
    logic [7:0]  ramp_reg,        ramp_next;
    logic [7:0]  ramp_limit_reg,  ramp_limit_next;
    logic        accel_reg,       accel_next;
    logic [15:0] slew_reg,        slew_next;
    mode_t       mode_reg,        mode_next;

    logic        going_lower;
    logic [15:0] move_len;
    logic [7:0]  lim_raw;
    logic [7:0]  move_lim;
    logic [15:0] move_slew;
    logic [23:0] product;
    logic        tick_step;
    logic        done;

    assign going_lower = $signed(position_reg) > item.target_position;
    assign move_len    = going_lower ? (position_reg - item.target_position)
                                     : (item.target_position - position_reg);
    assign lim_raw     = (move_len < SHORT_MOVE_LEN) ? move_len[9:2] : RAMP_CAP;
    assign move_lim    = (lim_raw > speed_limit_reg) ? speed_limit_reg : lim_raw;
    assign move_slew   = move_len - {7'd0, move_lim, 1'b0} - 16'd1;
    assign product     = 24'(scale_reg) * 24'(rd_data);

    always_comb begin
        scale_next       = scale_reg;
        speed_limit_next = speed_limit_reg;
        if (cfg.en) begin
            unique case (cfg.index)
                CFG_INTERVAL_SCALE: scale_next       = cfg.data;
                CFG_SPEED_LIMIT:    speed_limit_next = cfg.data;
                default: ;
            endcase
        end
    end

    always_comb begin
        position_next   = position_reg;
        phase_next      = phase_reg;
        dir_next        = dir_reg;
        ramp_next       = ramp_reg;
        ramp_limit_next = ramp_limit_reg;
        accel_next      = accel_reg;
        slew_next       = slew_reg;
        mode_next       = mode_reg;
        tick_step       = 1'b0;
        done            = 1'b0;
        if (fire) begin
            unique case (item.cmd)
                CMD_MOVE: begin
                    dir_next        = going_lower ? DIR_LOWER : DIR_HIGHER;
                    ramp_limit_next = move_lim;
                    ramp_next       = 8'd0;
                    accel_next      = 1'b1;
                    if (move_len == 16'd0) begin
                        slew_next = 16'd0;
                        mode_next = MODE_IDLE;
                        dir_next  = DIR_STOP;
                        done      = 1'b1;
                    end else begin
                        slew_next = move_slew;
                        mode_next = MODE_MOVE;
                    end
                end
                CMD_TICK: begin
                    if (mode_reg != MODE_IDLE) begin
                        tick_step = 1'b1;
                        unique case (dir_reg)
                            DIR_LOWER: begin
                                phase_next    = phase_reg + 2'd1;
                                position_next = position_reg - 16'd1;
                            end
                            DIR_HIGHER: begin
                                phase_next    = phase_reg + 2'd3;
                                position_next = position_reg + 16'd1;
                            end
                            default: ;
                        endcase
                        if (mode_reg == MODE_JOG) begin
                            if (ramp_reg < JOG_RAMP_LIMIT) begin
                                ramp_next = ramp_reg + 8'd1;
                            end
                        end else begin
                            priority if (accel_reg && (ramp_reg < ramp_limit_reg)) begin
                                ramp_next = ramp_reg + 8'd1;
                            end else if (!accel_reg && (ramp_reg != 8'd0)) begin
                                ramp_next = ramp_reg - 8'd1;
                            end else if (slew_reg == 16'd0) begin
                                accel_next = 1'b0;
                            end else begin
                                slew_next = slew_reg - 16'd1;
                            end
                            if ((slew_next == 16'd0) && (ramp_next == 8'd0)) begin
                                mode_next = MODE_IDLE;
                                dir_next  = DIR_STOP;
                                done      = 1'b1;
                            end
                        end
                    end
                end
                CMD_SET_POSITION: begin
                    position_next = item.target_position;
                end
                CMD_JOG: begin
                    dir_next  = item.jog_toward_lower ? DIR_LOWER : DIR_HIGHER;
                    ramp_next = 8'd0;
                    mode_next = MODE_JOG;
                end
                CMD_STOP: begin
                    mode_next = MODE_IDLE;
                    dir_next  = DIR_STOP;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        tbl_wr.en   = fire && (item.cmd == CMD_TABLE_WRITE)
                      && ({1'b0, item.table_address} < 9'(TABLE_DEPTH));
        tbl_wr.addr = item.table_address[TABLE_AW-1:0];
        tbl_wr.data = item.table_word;
        rd_addr     = table_slot(ramp_next);
    end

    always_comb begin
        res.coil_pattern  = (mode_next != MODE_IDLE) ? phase_coils(phase_next) : COILS_OFF;
        res.position_now  = position_next;
        res.next_interval = tick_step ? product[23:8] : 16'd0;
        res.step_taken    = tick_step;
        res.move_done     = done;
        res.busy_res      = (mode_next != MODE_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg       <= SCALE_RESET;
            speed_limit_reg <= SPEED_LIMIT_RESET;
            position_reg    <= 16'd0;
            phase_reg       <= 2'd0;
            dir_reg         <= DIR_STOP;
            ramp_reg        <= 8'd0;
            ramp_limit_reg  <= RAMP_LIMIT_RESET;
            accel_reg       <= 1'b1;
            slew_reg        <= 16'd0;
            mode_reg        <= MODE_IDLE;
        end else begin
            scale_reg       <= scale_next;
            speed_limit_reg <= speed_limit_next;
            position_reg    <= position_next;
            phase_reg       <= phase_next;
            dir_reg         <= dir_next;
            ramp_reg        <= ramp_next;
            ramp_limit_reg  <= ramp_limit_next;
            accel_reg       <= accel_next;
            slew_reg        <= slew_next;
            mode_reg        <= mode_next;
        end
    end

endmodule

`default_nettype wire

[sv/stepper_trapezoid_ramp_controller.sv]
// Stepper ramp controller: takes one request per cycle unless m_ready stalls the
// output, and returns one result for each; an accepted request waits in the request
// register, which feeds the ramp core, whose result is held in an output register so
// a new request is taken while a result waits. The acceleration table entry for the
// current ramp index is fetched ahead of each tick through the registered read port,
// so a tick, its table read and its 8 x 16 interval multiply complete together.
// The table has no reset and no clearing pass: load every entry a move or jog can
// reach before issuing ticks. Write the two registers only while the block is idle.
`default_nettype none

module stepper_trapezoid_ramp_controller
    import strc_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [2:0]         s_cmd,
    input  wire logic signed [15:0] s_target_position,
    input  wire logic               s_jog_toward_lower,
    input  wire logic [7:0]         s_table_address,
    input  wire logic [15:0]        s_table_word,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [2:0]              m_coil_pattern,
    output logic signed [15:0]      m_position_now,
    output logic [15:0]             m_next_interval,
    output logic                    m_step_taken,
    output logic                    m_move_done,
    output logic                    m_busy_res,
    input  wire logic               cfg_we,
    input  wire logic [0:0]         cfg_index,
    input  wire logic [7:0]         cfg_data
);

    item_t               in_item;
    item_t               in_item_reg;
    logic                in_valid_reg;
    result_t             out_res_reg;
    logic                out_valid_reg;
    logic                fire;
    result_t             core_res;
    tbl_wr_t             tbl_wr;
    logic [TABLE_AW-1:0] rd_addr;
    logic [15:0]         rd_data;
    cfg_wr_t             cfg;

    assign in_item.cmd              = s_cmd;
    assign in_item.target_position  = s_target_position;
    assign in_item.jog_toward_lower = s_jog_toward_lower;
    assign in_item.table_address    = s_table_address;
    assign in_item.table_word       = s_table_word;

    assign cfg.en    = cfg_we;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    assign fire    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= in_item;
        end
    end

    strc_table u_table (
        .aclk    (aclk),
        .wr      (tbl_wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    strc_ramp_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .fire    (fire),
        .item    (in_item_reg),
        .rd_data (rd_data),
        .tbl_wr  (tbl_wr),
        .rd_addr (rd_addr),
        .res     (core_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_res_reg <= core_res;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_coil_pattern  = out_res_reg.coil_pattern;
    assign m_position_now  = out_res_reg.position_now;
    assign m_next_interval = out_res_reg.next_interval;
    assign m_step_taken    = out_res_reg.step_taken;
    assign m_move_done     = out_res_reg.move_done;
    assign m_busy_res      = out_res_reg.busy_res;

endmodule

`default_nettype wire

[sv/strc_checker.sv]
// Port-level checker for the stepper ramp controller, bound to the top level.
// Depends on strc_pkg and the assertion macros in the defines header.
`default_nettype none

`include "stepper_trapezoid_ramp_controller_defines.svh"

module strc_checker
    import strc_pkg::*;
(
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic [2:0]         m_coil_pattern,
    input wire logic signed [15:0] m_position_now,
    input wire logic [15:0]        m_next_interval,
    input wire logic               m_step_taken,
    input wire logic               m_move_done,
    input wire logic               m_busy_res
);

    `STRC_ASSERT_NEXT(a_result_held, m_valid && !m_ready, m_valid && $stable(m_position_now) && $stable(m_next_interval), "Stalled result changed or was dropped.")
    `STRC_ASSERT_IMP(a_done_idle, m_valid && m_move_done, !m_busy_res, "Move done reported while still busy.")
    `STRC_ASSERT_IMP(a_idle_coils_off, m_valid && !m_busy_res, m_coil_pattern == COILS_OFF, "Coils driven while idle.")
    `STRC_ASSERT_IMP(a_step_active, m_valid && m_step_taken, m_busy_res || m_move_done, "Step taken outside a move or jog.")
    `STRC_ASSERT_IMP(a_no_step_no_interval, m_valid && !m_step_taken, m_next_interval == 16'd0, "Interval reported without a step.")

endmodule

bind stepper_trapezoid_ramp_controller strc_checker u_strc_checker (.*);

`default_nettype wire

[tb/ramp_scoreboard_pkg.sv]
// Scoreboard class for the stepper ramp controller testbench: predicts each result
// from accepted requests and compares the returned results in order.
// Depends on strc_pkg for the request and result types and the block constants.
`timescale 1ns / 1ps

package ramp_scoreboard_pkg;

    import strc_pkg::*;

    class ramp_scoreboard;
        logic [7:0]         scale;
        logic [7:0]         speed_limit;
        logic signed [15:0] position;
        logic [1:0]         phase;
        dir_t               dir;
        logic [7:0]         ramp_idx;
        logic [7:0]         ramp_lim;
        logic               accel;
        logic [15:0]        slew_left;
        mode_t              mode;
        logic [15:0]        accel_tbl [TABLE_DEPTH];
        result_t            predicted_outputs [$];
        int                 fail_count;

        function new();
            scale       = SCALE_RESET;
            speed_limit = SPEED_LIMIT_RESET;
            position    = '0;
            phase       = '0;
            dir         = DIR_STOP;
            ramp_idx    = '0;
            ramp_lim    = RAMP_LIMIT_RESET;
            accel       = 1'b1;
            slew_left   = '0;
            mode        = MODE_IDLE;
            fail_count  = 0;
        endfunction

        task report(string msg);
            fail_count++;
            $display("%0t ERROR %s", $time, msg);
        endtask

        function void set_register(logic [0:0] idx, logic [7:0] value);
            if (idx == CFG_INTERVAL_SCALE) begin
                scale = value;
            end else begin
                speed_limit = value;
            end
        endfunction

        function void predict_request(item_t req);
            int          cur;
            int          goal;
            int          len;
            int          lim;
            int          slot;
            logic [15:0] interval;
            logic        stepped;
            logic        done;
            result_t     res;
            interval = '0;
            stepped  = 1'b0;
            done     = 1'b0;
            case (req.cmd)
                CMD_MOVE: begin
                    cur  = int'(position);
                    goal = int'(req.target_position);
                    if (cur > goal) begin
                        dir = DIR_LOWER;
                        len = cur - goal;
                    end else begin
                        dir = DIR_HIGHER;
                        len = goal - cur;
                    end
                    lim = (len < int'(SHORT_MOVE_LEN)) ? len / 4 : int'(RAMP_CAP);
                    if (lim > int'(speed_limit)) begin
                        lim = int'(speed_limit);
                    end
                    ramp_lim = 8'(lim);
                    ramp_idx = '0;
                    accel    = 1'b1;
                    if (len == 0) begin
                        slew_left = '0;
                        mode      = MODE_IDLE;
                        dir       = DIR_STOP;
                        done      = 1'b1;
                    end else begin
                        slew_left = 16'(len - 2 * lim - 1);
                        mode      = MODE_MOVE;
                    end
                end
                CMD_TICK: begin
                    if (mode != MODE_IDLE) begin
                        if (dir == DIR_LOWER) begin
                            phase    = phase + 2'd1;
                            position = position - 16'sd1;
                        end else if (dir == DIR_HIGHER) begin
                            phase    = phase + 2'd3;
                            position = position + 16'sd1;
                        end
                        stepped  = 1'b1;
                        slot     = (int'(ramp_idx) >= TABLE_DEPTH) ? TABLE_DEPTH - 1
                                                                   : int'(ramp_idx);
                        interval = 16'((32'(scale) * 32'(accel_tbl[slot])) >> 8);
                        if (mode == MODE_JOG) begin
                            if (ramp_idx < JOG_RAMP_LIMIT) begin
                                ramp_idx++;
                            end
                        end else begin
                            if (accel && ramp_idx < ramp_lim) begin
                                ramp_idx++;
                            end else if (!accel && ramp_idx != 0) begin
                                ramp_idx--;
                            end else if (slew_left == 0) begin
                                accel = 1'b0;
                            end else begin
                                slew_left--;
                            end
                            if (slew_left == 0 && ramp_idx == 0) begin
                                mode = MODE_IDLE;
                                dir  = DIR_STOP;
                                done = 1'b1;
                            end
                        end
                    end
                end
                CMD_TABLE_WRITE: begin
                    if (int'(req.table_address) < TABLE_DEPTH) begin
                        accel_tbl[req.table_address] = req.table_word;
                    end
                end
                CMD_SET_POSITION: begin
                    position = req.target_position;
                end
                CMD_JOG: begin
                    dir      = req.jog_toward_lower ? DIR_LOWER : DIR_HIGHER;
                    ramp_idx = '0;
                    mode     = MODE_JOG;
                end
                CMD_STOP: begin
                    mode = MODE_IDLE;
                    dir  = DIR_STOP;
                end
                default: begin
                end
            endcase
            if (mode == MODE_IDLE) begin
                res.coil_pattern = COILS_OFF;
            end else begin
                case (phase)
                    2'd0:    res.coil_pattern = 3'd0;
                    2'd1:    res.coil_pattern = 3'd1;
                    2'd2:    res.coil_pattern = 3'd3;
                    default: res.coil_pattern = 3'd2;
                endcase
            end
            res.position_now  = position;
            res.next_interval = interval;
            res.step_taken    = stepped;
            res.move_done     = done;
            res.busy_res      = (mode != MODE_IDLE);
            predicted_outputs.push_back(res);
        endfunction

        task compare_field(string name, logic [15:0] got, logic [15:0] want);
            if (got !== want) begin
                report($sformatf("%s got %0h expected %0h", name, got, want));
            end
        endtask

        task check_output(result_t got);
            result_t want;
            if (predicted_outputs.size() == 0) begin
                report("result returned with no request outstanding");
                return;
            end
            want = predicted_outputs.pop_front();
            compare_field("coil_pattern", 16'(got.coil_pattern), 16'(want.coil_pattern));
            compare_field("position_now", 16'(got.position_now), 16'(want.position_now));
            compare_field("next_interval", got.next_interval, want.next_interval);
            compare_field("step_taken", 16'(got.step_taken), 16'(want.step_taken));
            compare_field("move_done", 16'(got.move_done), 16'(want.move_done));
            compare_field("busy_res", 16'(got.busy_res), 16'(want.busy_res));
        endtask
    endclass

endpackage

[tb/testbench.sv]
// Top-level testbench of the stepper ramp controller: drives requests and register
// writes with random gaps and stalls, and checks every result on the scoreboard.
// Depends on strc_pkg, ramp_scoreboard_pkg and the stepper_trapezoid_ramp_controller RTL.
`timescale 1ns / 1ps

module testbench;

    import strc_pkg::*;
    import ramp_scoreboard_pkg::*;

    localparam logic [2:0] CMD_SPARE_A     = 3'd6;
    localparam logic [2:0] CMD_SPARE_B     = 3'd7;
    localparam int         HOLD_OFF_CYCLES = 200;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [2:0]         s_cmd;
    logic signed [15:0] s_target_position;
    logic               s_jog_toward_lower;
    logic [7:0]         s_table_address;
    logic [15:0]        s_table_word;
    logic               m_valid;
    logic               m_ready;
    logic [2:0]         m_coil_pattern;
    logic signed [15:0] m_position_now;
    logic [15:0]        m_next_interval;
    logic               m_step_taken;
    logic               m_move_done;
    logic               m_busy_res;
    logic               cfg_we;
    logic [0:0]         cfg_index;
    logic [7:0]         cfg_data;

    ramp_scoreboard sb;
    int             requests_sent;
    int             ready_stall;
    bit             no_idle;
    bit             burst;
    bit             hold_off_request;
    result_t        observed;

    stepper_trapezoid_ramp_controller u_top (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_cmd              (s_cmd),
        .s_target_position  (s_target_position),
        .s_jog_toward_lower (s_jog_toward_lower),
        .s_table_address    (s_table_address),
        .s_table_word       (s_table_word),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_coil_pattern     (m_coil_pattern),
        .m_position_now     (m_position_now),
        .m_next_interval    (m_next_interval),
        .m_step_taken       (m_step_taken),
        .m_move_done        (m_move_done),
        .m_busy_res         (m_busy_res),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    always #5 aclk = ~aclk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 88) begin
            return $urandom_range(1, 3);
        end else if (r < 98) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 50);
    endfunction

    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) begin
            return 0;
        end else if (r < 75) begin
            return $urandom_range(1, 30);
        end else if (r < 95) begin
            return $urandom_range(31, 150);
        end
        return $urandom_range(151, 400);
    endfunction

    function automatic logic [15:0] near_target(int len);
        int goal;
        goal = int'(sb.position) + ($urandom_range(0, 1) ? len : -len);
        if (goal > 32767) begin
            goal = 32767;
        end
        if (goal < -32768) begin
            goal = -32768;
        end
        return 16'(goal);
    endfunction

    function automatic item_t random_request(logic [2:0] code);
        item_t req;
        req.cmd              = code;
        req.target_position  = 16'($urandom);
        req.jog_toward_lower = 1'($urandom);
        req.table_address    = 8'($urandom);
        req.table_word       = 16'($urandom);
        return req;
    endfunction

    task automatic send_request(item_t req);
        int gap;
        gap = (no_idle || burst) ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid            <= 1'b1;
        s_cmd              <= req.cmd;
        s_target_position  <= req.target_position;
        s_jog_toward_lower <= req.jog_toward_lower;
        s_table_address    <= req.table_address;
        s_table_word       <= req.table_word;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.predict_request(req);
        requests_sent++;
    endtask

    task automatic follow_move(int disrupt_pct);
        int    n;
        item_t req;
        n = 0;
        while (sb.mode == MODE_MOVE && n < 3000) begin
            if ($urandom_range(0, 99) < disrupt_pct) begin
                case ($urandom_range(0, 4))
                    0: req = random_request(CMD_STOP);
                    1: req = random_request(CMD_SET_POSITION);
                    2: req = random_request(CMD_TABLE_WRITE);
                    3: req = random_request($urandom_range(0, 1) ? CMD_SPARE_A : CMD_SPARE_B);
                    default: begin
                        req = random_request(CMD_MOVE);
                        req.target_position = near_target(pick_length());
                    end
                endcase
            end else begin
                req = random_request(CMD_TICK);
            end
            send_request(req);
            n++;
        end
    endtask

    task automatic drain(int tail);
        s_valid <= 1'b0;
        while (sb.predicted_outputs.size() != 0) @(posedge aclk);
        repeat (tail) @(posedge aclk);
    endtask

    task automatic write_registers(logic [7:0] scale, logic [7:0] speed_limit);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_INTERVAL_SCALE;
        cfg_data  <= scale;
        @(posedge aclk);
        sb.set_register(CFG_INTERVAL_SCALE, scale);
        cfg_index <= CFG_SPEED_LIMIT;
        cfg_data  <= speed_limit;
        @(posedge aclk);
        sb.set_register(CFG_SPEED_LIMIT, speed_limit);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic run_random(int budget);
        int    start;
        int    r;
        item_t req;
        start = requests_sent;
        while (requests_sent - start < budget) begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                req = random_request(CMD_MOVE);
                req.target_position = near_target(pick_length());
                send_request(req);
                follow_move(3);
            end else if (r < 75) begin
                send_request(random_request(CMD_JOG));
                repeat ($urandom_range(3, 40)) send_request(random_request(CMD_TICK));
                if ($urandom_range(0, 99) < 70) begin
                    send_request(random_request(CMD_STOP));
                end else begin
                    req = random_request(CMD_MOVE);
                    req.target_position = near_target(pick_length());
                    send_request(req);
                    follow_move(3);
                end
            end else if (r < 85) begin
                send_request(random_request(CMD_TABLE_WRITE));
            end else begin
                send_request(random_request(3'($urandom_range(0, 7))));
            end
        end
    endtask

    initial begin
        #(8_000_000);
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        m_ready     <= 1'b0;
        ready_stall = 0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                observed.coil_pattern  = m_coil_pattern;
                observed.position_now  = m_position_now;
                observed.next_interval = m_next_interval;
                observed.step_taken    = m_step_taken;
                observed.move_done     = m_move_done;
                observed.busy_res      = m_busy_res;
                sb.check_output(observed);
            end
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                ready_stall = HOLD_OFF_CYCLES;
            end
            if (ready_stall > 0) begin
                ready_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (!no_idle) begin
                    ready_stall = pick_gap();
                end
            end
        end
    end

    initial begin
        int    i;
        item_t req;
        sb               = new();
        requests_sent    = 0;
        no_idle          = 1'b0;
        burst            = 1'b0;
        hold_off_request = 1'b0;
        aresetn            <= 1'b0;
        s_valid            <= 1'b0;
        s_cmd              <= '0;
        s_target_position  <= '0;
        s_jog_toward_lower <= 1'b0;
        s_table_address    <= '0;
        s_table_word       <= '0;
        cfg_we             <= 1'b0;
        cfg_index          <= '0;
        cfg_data           <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Every table entry is loaded before the first tick so no read sees an unwritten slot.
        for (i = 0; i < TABLE_DEPTH; i++) begin
            req = random_request(CMD_TABLE_WRITE);
            req.table_address = 8'(i);
            if (i == 0) begin
                req.table_word = 16'hFFFF;
            end else if (i == 1) begin
                req.table_word = 16'h0000;
            end
            send_request(req);
        end

        send_request(random_request(CMD_TICK));
        send_request(random_request(CMD_SPARE_A));
        send_request(random_request(CMD_SPARE_B));
        send_request(random_request(CMD_STOP));
        req = random_request(CMD_MOVE);
        req.target_position = sb.position;
        send_request(req);
        req = random_request(CMD_SET_POSITION);
        req.target_position = 16'sh7FFF;
        send_request(req);
        req = random_request(CMD_JOG);
        req.jog_toward_lower = 1'b0;
        send_request(req);
        repeat (2) send_request(random_request(CMD_TICK));
        req = random_request(CMD_MOVE);
        req.target_position = 16'sh7FFF;
        send_request(req);
        repeat (3) send_request(random_request(CMD_TICK));
        send_request(random_request(CMD_STOP));
        req = random_request(CMD_SET_POSITION);
        req.target_position = 16'sh8000;
        send_request(req);
        req = random_request(CMD_JOG);
        req.jog_toward_lower = 1'b1;
        send_request(req);
        repeat (2) send_request(random_request(CMD_TICK));
        req = random_request(CMD_SET_POSITION);
        req.target_position = 16'sd100;
        send_request(req);
        send_request(random_request(CMD_TICK));
        send_request(random_request(CMD_STOP));
        req = random_request(CMD_MOVE);
        req.target_position = 16'sd103;
        send_request(req);
        follow_move(0);
        send_request(random_request(CMD_TICK));
        req = random_request(CMD_MOVE);
        req.target_position = 16'sd90;
        send_request(req);
        follow_move(0);
        run_random(250);

        drain(4);
        write_registers(8'd255, 8'd255);
        req = random_request(CMD_SET_POSITION);
        req.target_position = 16'sd0;
        send_request(req);
        req = random_request(CMD_MOVE);
        req.target_position = 16'(1024 + $urandom_range(0, 15));
        send_request(req);
        repeat (300) send_request(random_request(CMD_TICK));
        send_request(random_request(CMD_STOP));
        run_random(450);

        drain(4);
        write_registers(8'd0, 8'd0);
        no_idle = 1'b1;
        run_random(150);
        no_idle = 1'b0;

        drain(4);
        write_registers(8'($urandom_range(1, 254)), 8'($urandom_range(1, 254)));
        hold_off_request = 1'b1;
        burst = 1'b1;
        send_request(random_request(CMD_JOG));
        repeat (40) send_request(random_request(CMD_TICK));
        send_request(random_request(CMD_STOP));
        burst = 1'b0;
        run_random(200);

        drain(10);
        if (sb.fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
